/* design/mfmt_pkg.sv */
// Shared types and constants for the motor feedback multi-turn tracker.
// Used by mfmt_scale_div and motor_feedback_multiturn_tracker; no dependencies.
package mfmt_pkg;

  localparam int unsigned NUM_SLOTS = 5;
  localparam int unsigned ID_W      = 11;
  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned TURN_W    = 16;
  localparam int unsigned TOTAL_W   = 30;
  localparam int unsigned MAG_W     = 29;
  localparam int unsigned SCALED_W  = 25;

  typedef enum logic [2:0] {
    SLOT_LIFT0 = 3'd0,
    SLOT_LIFT1 = 3'd1,
    SLOT_PITCH = 3'd2,
    SLOT_YAW   = 3'd3,
    SLOT_ROLL  = 3'd4
  } slot_e;

  typedef enum logic [1:0] {
    REG_LIFT_FIRST_ID  = 2'd0,
    REG_CLAMP_PITCH_ID = 2'd1,
    REG_CLAMP_YAW_ID   = 2'd2,
    REG_CLAMP_ROLL_ID  = 2'd3
  } reg_idx_e;

  localparam logic [ID_W-1:0] LIFT_FIRST_ID_RST  = 11'd513;
  localparam logic [ID_W-1:0] CLAMP_PITCH_ID_RST = 11'd515;
  localparam logic [ID_W-1:0] CLAMP_YAW_ID_RST   = 11'd517;
  localparam logic [ID_W-1:0] CLAMP_ROLL_ID_RST  = 11'd518;

  localparam logic signed [ANGLE_W:0]    WRAP_HIGH      = 17'sd4096;
  localparam logic signed [ANGLE_W:0]    WRAP_LOW       = -17'sd4096;
  localparam logic signed [TURN_W-1:0]   TURN_MAX       = 16'sh7fff;
  localparam logic signed [TURN_W-1:0]   TURN_MIN       = 16'sh8000;
  localparam logic signed [TOTAL_W-1:0]  TICKS_PER_TURN = 30'sd8191;

  // Stage enables for the scaling pipeline
  typedef struct packed {
    logic load_mul;
    logic load_out;
  } div_ctrl_t;

endpackage

/* design/motor_feedback_multiturn_tracker.sv */
// Multi-turn position tracker for motor feedback frames; top level.
// Pipeline: an accepted frame passes the input register, state update, reciprocal
// multiply and result register. Throughput: one frame per cycle while the output is not stalled.
// Reset: ID registers return to 513/515/517/518, per-slot angle and turn state clears
// to zero, and the pipeline empties; no clearing pass. Depends on mfmt_pkg, mfmt_scale_div.
module motor_feedback_multiturn_tracker #(
  parameter int unsigned POSITION_DIVISOR = 19
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [3:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  // frame input
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [10:0]                           frame_id_i,
  input  logic [7:0]                            byte0_i,
  input  logic [7:0]                            byte1_i,
  input  logic [7:0]                            byte2_i,
  input  logic [7:0]                            byte3_i,
  input  logic [7:0]                            byte4_i,
  input  logic [7:0]                            byte5_i,
  input  logic [7:0]                            byte6_i,
  // result output
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [2:0]                            motor_slot_o,
  output logic [15:0]                           angle_o,
  output logic signed [15:0]                    speed_rpm_o,
  output logic signed [15:0]                    drive_current_o,
  output logic [7:0]                            temperature_o,
  output logic signed [15:0]                    turn_count_o,
  output logic signed [29:0]                    total_position_o,
  output logic signed [24:0]                    scaled_position_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [mfmt_pkg::ID_W-1:0] lift_first_id_q, clamp_pitch_id_q;
  logic [mfmt_pkg::ID_W-1:0] clamp_yaw_id_q, clamp_roll_id_q;
  logic                      cfg_write;
  mfmt_pkg::reg_idx_e        cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_idx   = mfmt_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lift_first_id_q  <= mfmt_pkg::LIFT_FIRST_ID_RST;
      clamp_pitch_id_q <= mfmt_pkg::CLAMP_PITCH_ID_RST;
      clamp_yaw_id_q   <= mfmt_pkg::CLAMP_YAW_ID_RST;
      clamp_roll_id_q  <= mfmt_pkg::CLAMP_ROLL_ID_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        mfmt_pkg::REG_LIFT_FIRST_ID:  lift_first_id_q  <= pwdata[mfmt_pkg::ID_W-1:0];
        mfmt_pkg::REG_CLAMP_PITCH_ID: clamp_pitch_id_q <= pwdata[mfmt_pkg::ID_W-1:0];
        mfmt_pkg::REG_CLAMP_YAW_ID:   clamp_yaw_id_q   <= pwdata[mfmt_pkg::ID_W-1:0];
        mfmt_pkg::REG_CLAMP_ROLL_ID:  clamp_roll_id_q  <= pwdata[mfmt_pkg::ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      mfmt_pkg::REG_LIFT_FIRST_ID:  prdata = {21'd0, lift_first_id_q};
      mfmt_pkg::REG_CLAMP_PITCH_ID: prdata = {21'd0, clamp_pitch_id_q};
      mfmt_pkg::REG_CLAMP_YAW_ID:   prdata = {21'd0, clamp_yaw_id_q};
      mfmt_pkg::REG_CLAMP_ROLL_ID:  prdata = {21'd0, clamp_roll_id_q};
      default:                      prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage loads when it is empty or its content
  // moves on; stall ripples back from the output register.
  // ---------------------------------------------------------------------------
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic s1_free, s2_free, s3_free, s4_free;
  logic s1_go, s2_go, s3_go;
  logic s1_hit;

  assign s4_free = !s4_vld_q || !out_stall_i;
  assign s3_free = !s3_vld_q || s4_free;
  assign s2_free = !s2_vld_q || s3_free;
  assign s1_free = !s1_vld_q || s2_free;
  assign s3_go   = s3_vld_q && s4_free;
  assign s2_go   = s2_vld_q && s3_free;
  assign s1_go   = s1_vld_q && s2_free;

  assign in_stall_o  = !s1_free;
  assign out_valid_o = s4_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      if (s1_free) s1_vld_q <= in_valid_i;
      // drop frames that match no slot
      if (s2_free) s2_vld_q <= s1_vld_q && s1_hit;
      if (s3_free) s3_vld_q <= s2_vld_q;
      if (s4_free) s4_vld_q <= s3_vld_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic [mfmt_pkg::ID_W-1:0] s1_id_q;
  logic [7:0] s1_b0_q, s1_b1_q, s1_b2_q, s1_b3_q, s1_b4_q, s1_b5_q, s1_b6_q;

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_id_q <= frame_id_i;
      s1_b0_q <= byte0_i;
      s1_b1_q <= byte1_i;
      s1_b2_q <= byte2_i;
      s1_b3_q <= byte3_i;
      s1_b4_q <= byte4_i;
      s1_b5_q <= byte5_i;
      s1_b6_q <= byte6_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Slot match, first hit wins. The second lift ID is computed at 12 bits so
  // that a first lift ID of 2047 leaves the second lift slot unreachable.
  // ---------------------------------------------------------------------------
  logic [mfmt_pkg::ID_W:0] lift_next_id;
  mfmt_pkg::slot_e         s1_slot;
  logic                    s1_full_fmt;

  assign lift_next_id = {1'b0, lift_first_id_q} + 12'd1;

  always_comb begin
    s1_hit  = 1'b1;
    s1_slot = mfmt_pkg::SLOT_LIFT0;
    if (s1_id_q == lift_first_id_q) begin
      s1_slot = mfmt_pkg::SLOT_LIFT0;
    end else if ({1'b0, s1_id_q} == lift_next_id) begin
      s1_slot = mfmt_pkg::SLOT_LIFT1;
    end else if (s1_id_q == clamp_pitch_id_q) begin
      s1_slot = mfmt_pkg::SLOT_PITCH;
    end else if (s1_id_q == clamp_yaw_id_q) begin
      s1_slot = mfmt_pkg::SLOT_YAW;
    end else if (s1_id_q == clamp_roll_id_q) begin
      s1_slot = mfmt_pkg::SLOT_ROLL;
    end else begin
      s1_hit = 1'b0;
    end
  end

  // Yaw and roll clamps report angle and speed only
  assign s1_full_fmt = (s1_slot == mfmt_pkg::SLOT_LIFT0) ||
                       (s1_slot == mfmt_pkg::SLOT_LIFT1) ||
                       (s1_slot == mfmt_pkg::SLOT_PITCH);

  // ---------------------------------------------------------------------------
  // Per-slot state and wrap tracking. Read and write happen in the same
  // cycle, so back-to-back frames of one slot see each other's update.
  // ---------------------------------------------------------------------------
  logic [mfmt_pkg::ANGLE_W-1:0]        last_angle_q [mfmt_pkg::NUM_SLOTS];
  logic signed [mfmt_pkg::TURN_W-1:0]  turns_q      [mfmt_pkg::NUM_SLOTS];
  logic [2:0]                          s1_idx;
  logic [mfmt_pkg::ANGLE_W-1:0]        s1_angle, prev_angle;
  logic signed [mfmt_pkg::TURN_W-1:0]  prev_turns, turns_d;
  logic signed [mfmt_pkg::ANGLE_W:0]   angle_diff;
  logic signed [mfmt_pkg::TOTAL_W-1:0] turns_ext, total_d;

  assign s1_idx   = s1_slot;
  assign s1_angle = {s1_b0_q, s1_b1_q};

  always_comb begin
    prev_angle = last_angle_q[s1_idx];
    prev_turns = turns_q[s1_idx];
    angle_diff = $signed({1'b0, s1_angle}) - $signed({1'b0, prev_angle});
    turns_d    = prev_turns;
    // big forward jump means the encoder wrapped backwards, and vice versa
    if (angle_diff > mfmt_pkg::WRAP_HIGH) begin
      if (prev_turns != mfmt_pkg::TURN_MIN) turns_d = prev_turns - 16'sd1;
    end else if (angle_diff < mfmt_pkg::WRAP_LOW) begin
      if (prev_turns != mfmt_pkg::TURN_MAX) turns_d = prev_turns + 16'sd1;
    end
    turns_ext = {{(mfmt_pkg::TOTAL_W - mfmt_pkg::TURN_W){turns_d[mfmt_pkg::TURN_W-1]}},
                 turns_d};
    total_d   = turns_ext * mfmt_pkg::TICKS_PER_TURN + $signed({14'd0, s1_angle});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < mfmt_pkg::NUM_SLOTS; k++) begin
        last_angle_q[k] <= '0;
        turns_q[k]      <= '0;
      end
    end else if (s1_go && s1_hit) begin
      last_angle_q[s1_idx] <= s1_angle;
      turns_q[s1_idx]      <= turns_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2 and 3: carry the fields alongside the scaling pipeline
  // ---------------------------------------------------------------------------
  logic [2:0]                          s2_slot_q, s3_slot_q;
  logic [15:0]                         s2_angle_q, s3_angle_q;
  logic signed [15:0]                  s2_speed_q, s3_speed_q;
  logic signed [15:0]                  s2_current_q, s3_current_q;
  logic [7:0]                          s2_temp_q, s3_temp_q;
  logic signed [15:0]                  s2_turns_q, s3_turns_q;
  logic signed [mfmt_pkg::TOTAL_W-1:0] s2_total_q, s3_total_q;

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_slot_q    <= s1_idx;
      s2_angle_q   <= s1_angle;
      s2_speed_q   <= {s1_b2_q, s1_b3_q};
      s2_current_q <= s1_full_fmt ? {s1_b4_q, s1_b5_q} : 16'sd0;
      s2_temp_q    <= s1_full_fmt ? s1_b6_q : 8'd0;
      s2_turns_q   <= turns_d;
      s2_total_q   <= total_d;
    end
    if (s2_go) begin
      s3_slot_q    <= s2_slot_q;
      s3_angle_q   <= s2_angle_q;
      s3_speed_q   <= s2_speed_q;
      s3_current_q <= s2_current_q;
      s3_temp_q    <= s2_temp_q;
      s3_turns_q   <= s2_turns_q;
      s3_total_q   <= s2_total_q;
    end
    // Stage 4: result register
    if (s3_go) begin
      motor_slot_o     <= s3_slot_q;
      angle_o          <= s3_angle_q;
      speed_rpm_o      <= s3_speed_q;
      drive_current_o  <= s3_current_q;
      temperature_o    <= s3_temp_q;
      turn_count_o     <= s3_turns_q;
      total_position_o <= s3_total_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Scaled position: multiply in stage 3, fix up into the result register
  // ---------------------------------------------------------------------------
  mfmt_pkg::div_ctrl_t div_ctrl;

  assign div_ctrl.load_mul = s2_go;
  assign div_ctrl.load_out = s3_go;

  mfmt_scale_div #(
    .DIVISOR (POSITION_DIVISOR)
  ) u_scale_div (
    .clk_i    (clk_i),
    .ctrl_i   (div_ctrl),
    .total_i  (s2_total_q),
    .scaled_o (scaled_position_o)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A matched frame leaves its angle in its slot's state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_hit) |=> (last_angle_q[$past(s1_idx)] == $past(s1_angle)))
    else $error("slot angle state not updated");

  // Total position agrees with turn count and angle at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(total_position_o) ==
                     32'(turn_count_o) * 32'sd8191 + $signed({16'd0, angle_o})))
    else $error("total position inconsistent with turn count");

  // Short-format slots report no current or temperature
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (motor_slot_o == mfmt_pkg::SLOT_YAW ||
                     motor_slot_o == mfmt_pkg::SLOT_ROLL))
      |-> (drive_current_o == 16'sd0 && temperature_o == 8'd0))
    else $error("current or temperature reported for yaw/roll slot");

endmodule

/* design/mfmt_scale_div.sv */
// Two-stage constant divider: total position / DIVISOR, truncated toward zero.
// Uses a reciprocal multiply that is exact for magnitudes below 2**MAG_W. Depends on mfmt_pkg.
module mfmt_scale_div #(
  parameter int unsigned DIVISOR = 19
) (
  input  logic                                  clk_i,
  input  mfmt_pkg::div_ctrl_t                   ctrl_i,
  input  logic signed [mfmt_pkg::TOTAL_W-1:0]   total_i,
  output logic signed [mfmt_pkg::SCALED_W-1:0]  scaled_o
);

  localparam int unsigned LOG2_DIV = $clog2(DIVISOR);
  localparam int unsigned SHIFT    = mfmt_pkg::MAG_W + LOG2_DIV;
  localparam int unsigned PROD_W   = 2 * mfmt_pkg::MAG_W + 1;
  localparam logic [63:0] MAGIC_FULL =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [mfmt_pkg::MAG_W:0] MAGIC = MAGIC_FULL[mfmt_pkg::MAG_W:0];

  logic [mfmt_pkg::TOTAL_W-1:0]  neg_total;
  logic [mfmt_pkg::MAG_W-1:0]    mag_d;
  logic [PROD_W-1:0]             prod_d, prod_q;
  logic                          neg_q;
  logic [PROD_W-1:0]             quo_full;
  logic [mfmt_pkg::TOTAL_W-1:0]  quo_ext, quo_signed;

  // Take the magnitude and multiply by the reciprocal
  always_comb begin
    neg_total = (~total_i) + 30'd1;
    mag_d     = total_i[mfmt_pkg::TOTAL_W-1] ? neg_total[mfmt_pkg::MAG_W-1:0]
                                             : total_i[mfmt_pkg::MAG_W-1:0];
    prod_d    = PROD_W'(mag_d) * PROD_W'(MAGIC);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_mul) begin
      prod_q <= prod_d;
      neg_q  <= total_i[mfmt_pkg::TOTAL_W-1];
    end
  end

  // Shift out the fraction and restore the sign
  always_comb begin
    quo_full   = prod_q >> SHIFT;
    quo_ext    = {1'b0, quo_full[mfmt_pkg::MAG_W-1:0]};
    quo_signed = neg_q ? ((~quo_ext) + 30'd1) : quo_ext;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      scaled_o <= quo_signed[mfmt_pkg::SCALED_W-1:0];
    end
  end

endmodule
